[rtl/wsf_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted 3x3 smoothing filter package
// Shared constants, types and register indexes of the smoothing filter.
// ----------------------------------------------------------------------------
package wsf_pkg;

   localparam int MAX_LINE_WIDTH = 4096;
   localparam int PIXEL_BITS     = 8;
   localparam int MAX_ROWS       = 4096;

   localparam int CFG_BITS  = 13;
   localparam int COL_BITS  = $clog2(MAX_LINE_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_ROWS);
   localparam int ADDR_BITS = $clog2(MAX_LINE_WIDTH);

   localparam logic [CFG_BITS-1:0] MIN_DIM      = CFG_BITS'(3);
   localparam logic [CFG_BITS-1:0] MAX_WIDTH    = CFG_BITS'(MAX_LINE_WIDTH);
   localparam logic [CFG_BITS-1:0] MAX_HEIGHT   = CFG_BITS'(MAX_ROWS);
   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

   localparam int TAP_COUNT  = 9;
   localparam int TAP_CENTER = 4;

   // The weighted sum is at most 11 full-scale pixels.
   localparam int SUM_BITS    = PIXEL_BITS + 4;
   localparam int RECIP_SHIFT = SUM_BITS + 3;
   localparam int RECIP       = (2 ** RECIP_SHIFT) / 11 + 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_SHIFT;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [QCNT_BITS-1:0]  qcount_type;
   typedef logic [0:0]            csr_addr_type;

   localparam csr_addr_type CSR_IMAGE_WIDTH  = 1'b0;
   localparam csr_addr_type CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      pixel_type [TAP_COUNT-1:0] taps;
      logic                      border;
      logic                      frame_end;
   } work_type;

endpackage

[rtl/weighted_3x3_smoothing_filter.sv]
// ----------------------------------------------------------------------------
// Weighted 3x3 smoothing filter
// Top level: configuration registers, front end, work queue and back end.
// ----------------------------------------------------------------------------
// The filter takes one grayscale pixel request per clock in raster order and
// sustains one request per clock as long as rsp_stall stays low; a request
// passes through the registered line buffer read, the work queue, the adder
// stage and the divider multiply stage before its result can appear on
// rsp_valid. Results trail the input by one row plus one pixel, so
// after the frame the host sends image_width + 1 requests with req_is_flush
// set to drain it; rsp_frame_end marks the bottom-right pixel. Border pixels
// pass through unchanged, interior pixels become the eight neighbors plus
// three times the center, divided by eleven and truncated. The line buffers
// are two RAMs of 4096 pixels and need no clearing after reset. Write
// image_width and image_height only while the filter is idle.
module weighted_3x3_smoothing_filter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  wsf_pkg::csr_addr_type csr_index,
   input  wsf_pkg::cfg_type      csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsf_pkg::pixel_type    req_pixel_value,
   input  logic                  req_is_flush,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsf_pkg::pixel_type    rsp_filtered_pixel,
   output logic                  rsp_frame_end
);

   import wsf_pkg::*;

   cfg_type    image_width_ff;
   cfg_type    image_height_ff;
   logic       push_valid;
   work_type   push_data;
   logic       work_pop;
   logic       work_valid;
   work_type   work_data;
   qcount_type queue_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   wsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .image_width     (image_width_ff),
      .image_height    (image_height_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .req_is_flush    (req_is_flush),
      .queue_count     (queue_count),
      .push_valid      (push_valid),
      .push_data       (push_data)
   );

   wsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (work_pop),
      .not_empty (work_valid),
      .head_data (work_data),
      .count     (queue_count)
   );

   wsf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .work_valid         (work_valid),
      .work_data          (work_data),
      .work_pop           (work_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_pixel (rsp_filtered_pixel),
      .rsp_frame_end      (rsp_frame_end)
   );

endmodule

[rtl/wsf_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module wsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/wsf_front.sv]
// ----------------------------------------------------------------------------
// Smoothing filter front end
// Tracks the raster position, keeps the two line buffers and the 3x3 window,
// and classifies each request as border, interior or no result.
// ----------------------------------------------------------------------------
module wsf_front (
   input  logic                clock,
   input  logic                reset,
   input  wsf_pkg::cfg_type    image_width,
   input  wsf_pkg::cfg_type    image_height,
   input  logic                req_valid,
   output logic                req_stall,
   input  wsf_pkg::pixel_type  req_pixel_value,
   input  logic                req_is_flush,
   input  wsf_pkg::qcount_type queue_count,
   output logic                push_valid,
   output wsf_pkg::work_type   push_data
);

   import wsf_pkg::*;

   cfg_type                 width_eff;
   cfg_type                 height_eff;
   logic [COL_BITS-1:0]     in_col_ff, in_col_in;
   cfg_type                 in_row_ff, in_row_in;
   logic [COL_BITS-1:0]     out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]     out_row_ff, out_row_in;
   logic                    out_of_range;
   logic [COL_BITS-1:0]     col;
   cfg_type                 row;
   logic [COL_BITS-1:0]     ocol;
   logic [ROW_BITS-1:0]     orow;
   cfg_type                 col_next;
   cfg_type                 ocol_next;
   logic                    accept;
   logic                    emit;
   logic                    last_col;
   logic                    last_row;
   logic                    border;
   logic                    frame_end;
   pixel_type               pixel;
   logic [QCNT_BITS:0]      pending;

   logic                    s1_valid_ff;
   logic                    s1_bank_ff;
   pixel_type               s1_pixel_ff;
   logic                    s1_emit_ff;
   logic                    s1_border_ff;
   logic                    s1_frame_end_ff;

   pixel_type               bank0_data;
   pixel_type               bank1_data;
   pixel_type               old_col;
   pixel_type               new_col;
   pixel_type [TAP_COUNT-1:0] taps_ff, taps_in;

   always_comb begin
      width_eff = image_width;
      if (image_width < MIN_DIM) begin
         width_eff = MIN_DIM;
      end else if (image_width > MAX_WIDTH) begin
         width_eff = MAX_WIDTH;
      end
      height_eff = image_height;
      if (image_height < MIN_DIM) begin
         height_eff = MIN_DIM;
      end else if (image_height > MAX_HEIGHT) begin
         height_eff = MAX_HEIGHT;
      end
   end

   // Counters left inconsistent by a register change start a new frame.
   assign out_of_range = (CFG_BITS'(in_col_ff) >= width_eff) ||
                         (in_row_ff > height_eff + CFG_BITS'(1)) ||
                         (CFG_BITS'(out_col_ff) >= width_eff) ||
                         (CFG_BITS'(out_row_ff) >= height_eff);

   assign col  = out_of_range ? '0 : in_col_ff;
   assign row  = out_of_range ? '0 : in_row_ff;
   assign ocol = out_of_range ? '0 : out_col_ff;
   assign orow = out_of_range ? '0 : out_row_ff;

   assign emit      = (row >= CFG_BITS'(2)) || ((row == CFG_BITS'(1)) && (col != '0));
   assign last_col  = CFG_BITS'(ocol) == width_eff - CFG_BITS'(1);
   assign last_row  = CFG_BITS'(orow) == height_eff - CFG_BITS'(1);
   assign border    = last_col || (ocol == '0) || (orow == '0) || last_row;
   assign frame_end = last_col && last_row;
   assign col_next  = CFG_BITS'(col) + CFG_BITS'(1);
   assign ocol_next = CFG_BITS'(ocol) + CFG_BITS'(1);
   assign pixel     = req_is_flush ? '0 : req_pixel_value;

   assign pending   = (QCNT_BITS+1)'(queue_count) + (QCNT_BITS+1)'(push_valid);
   assign req_stall = pending >= (QCNT_BITS+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_col_in  = col;
      in_row_in  = row;
      out_col_in = ocol;
      out_row_in = orow;
      if (col_next == width_eff) begin
         in_col_in = '0;
         in_row_in = row + CFG_BITS'(1);
      end else begin
         in_col_in = col_next[COL_BITS-1:0];
      end
      if (emit) begin
         if (frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (ocol_next == width_eff) begin
            out_col_in = '0;
            out_row_in = orow + ROW_BITS'(1);
         end else begin
            out_col_in = ocol_next[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bank_ff      <= row[0];
         s1_pixel_ff     <= pixel;
         s1_emit_ff      <= emit;
         s1_border_ff    <= border;
         s1_frame_end_ff <= frame_end;
      end
   end

   // Bank b holds the latest row whose parity is b.
   wsf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && !row[0]),
      .wr_addr (col[ADDR_BITS-1:0]),
      .wr_data (pixel),
      .rd_en   (accept),
      .rd_addr (col[ADDR_BITS-1:0]),
      .rd_data (bank0_data)
   );

   wsf_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && row[0]),
      .wr_addr (col[ADDR_BITS-1:0]),
      .wr_data (pixel),
      .rd_en   (accept),
      .rd_addr (col[ADDR_BITS-1:0]),
      .rd_data (bank1_data)
   );

   assign old_col = s1_bank_ff ? bank1_data : bank0_data;
   assign new_col = s1_bank_ff ? bank0_data : bank1_data;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         taps_in[3*i]   = taps_ff[3*i+1];
         taps_in[3*i+1] = taps_ff[3*i+2];
      end
      taps_in[2] = old_col;
      taps_in[5] = new_col;
      taps_in[8] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else if (s1_valid_ff) begin
         taps_ff <= taps_in;
      end
   end

   assign push_valid          = s1_valid_ff && s1_emit_ff;
   assign push_data.taps      = taps_in;
   assign push_data.border    = s1_border_ff;
   assign push_data.frame_end = s1_frame_end_ff;

`ifndef SYNTH
   a_frame_end_on_border: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_data.frame_end |-> push_data.border)
      else $error("Frame end marked on an interior pixel.");

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && emit && frame_end |=>
         (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
      else $error("Counters not cleared after the last pixel of a frame.");
`endif

endmodule

[rtl/wsf_queue.sv]
// ----------------------------------------------------------------------------
// Smoothing filter work queue
// Short first-in first-out queue of classified windows between front and back.
// ----------------------------------------------------------------------------
module wsf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsf_pkg::work_type   push_data,
   input  logic                pop,
   output logic                not_empty,
   output wsf_pkg::work_type   head_data,
   output wsf_pkg::qcount_type count
);

   import wsf_pkg::*;

   work_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   qcount_type             count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != '0;
   assign head_data = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < QCNT_BITS'(QUEUE_DEPTH))
      else $error("Work queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("Work queue read while empty.");
`endif

endmodule

[rtl/wsf_back.sv]
// ----------------------------------------------------------------------------
// Smoothing filter back end
// Weighted sum divided by eleven, or border centre kept; the result is held.
// ----------------------------------------------------------------------------
module wsf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   input  wsf_pkg::work_type  work_data,
   output logic               work_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wsf_pkg::pixel_type rsp_filtered_pixel,
   output logic               rsp_frame_end
);

   import wsf_pkg::*;

   logic [SUM_BITS-1:0]  sum;
   logic                 out_free;
   logic                 sum_free;

   logic                 sum_valid_ff;
   logic [SUM_BITS-1:0]  sum_ff;
   pixel_type            center_ff;
   logic                 border_ff;
   logic                 frame_end_ff;

   logic [PROD_BITS-1:0] product;
   pixel_type            quotient;

   logic                 rsp_valid_ff;
   pixel_type            rsp_pixel_ff;
   logic                 rsp_frame_end_ff;

   // The centre pixel carries weight three.
   always_comb begin
      sum = SUM_BITS'(work_data.taps[TAP_CENTER]) << 1;
      for (int k = 0; k < TAP_COUNT; k++) begin
         sum = sum + SUM_BITS'(work_data.taps[k]);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sum_free = !sum_valid_ff || out_free;
   assign work_pop = work_valid && sum_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (sum_free) begin
            sum_valid_ff <= work_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         sum_ff       <= sum;
         center_ff    <= work_data.taps[TAP_CENTER];
         border_ff    <= work_data.border;
         frame_end_ff <= work_data.frame_end;
      end
   end

   // Division by eleven through a scaled reciprocal, exact over the sum range.
   assign product  = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP);
   assign quotient = product[RECIP_SHIFT +: PIXEL_BITS];

   always_ff @(posedge clock) begin
      if (out_free && sum_valid_ff) begin
         rsp_pixel_ff     <= border_ff ? center_ff : quotient;
         rsp_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_pixel = rsp_pixel_ff;
   assign rsp_frame_end      = rsp_frame_end_ff;

`ifndef SYNTH
   a_interior_in_range: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !border_ff |-> sum_ff <= SUM_BITS'(11 * (2 ** PIXEL_BITS - 1)))
      else $error("Weighted sum exceeds its range.");
`endif

endmodule

[tb/sv/weighted_3x3_smoothing_filter_test.sv]
// ----------------------------------------------------------------------------
// Weighted 3x3 smoothing filter testbench
// Streams grayscale frames through the filter under random request gaps and
// result stalls, predicts every smoothed pixel with its own line store and
// window, and compares each result field by field in order of arrival.
// ----------------------------------------------------------------------------
module weighted_3x3_smoothing_filter_test;

   import wsf_pkg::*;

   localparam int unsigned TARGET_ITEMS  = 800;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned REPORT_CAP    = 40;

   typedef struct {
      pixel_type pixel;
      logic      flush;
   } pixel_req_type;

   typedef struct {
      pixel_type pixel;
      logic      frame_end;
   } smoothed_pixel_type;

   logic         clock              = 1'b0;
   logic         reset              = 1'b1;
   logic         csr_write_enable   = 1'b0;
   csr_addr_type csr_index          = CSR_IMAGE_WIDTH;
   cfg_type      csr_write_data     = '0;
   logic         req_valid          = 1'b0;
   logic         req_stall;
   pixel_type    req_pixel_value    = '0;
   logic         req_is_flush       = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall          = 1'b0;
   pixel_type    rsp_filtered_pixel;
   logic         rsp_frame_end;

   pixel_req_type      pixel_backlog [$];
   smoothed_pixel_type smoothed_due [$];
   pixel_req_type      staged_req;
   smoothed_pixel_type due_pixel;

   // Predictor state.
   pixel_type   line_mem [2*MAX_LINE_WIDTH];
   pixel_type   taps [3][3];
   cfg_type     width_reg  = WIDTH_RESET;
   cfg_type     height_reg = HEIGHT_RESET;
   int unsigned in_col     = 0;
   int unsigned in_row     = 0;
   int unsigned out_col    = 0;
   int unsigned out_row    = 0;

   int unsigned error_count  = 0;
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned stall_left   = 0;
   int unsigned quiet_cycles = 0;

   weighted_3x3_smoothing_filter dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_value    (req_pixel_value),
      .req_is_flush       (req_is_flush),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_pixel (rsp_filtered_pixel),
      .rsp_frame_end      (rsp_frame_end)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic flag_error(input string what);
      if (error_count < REPORT_CAP) begin
         $display("mismatch: %s", what);
      end
      error_count++;
   endtask

   function automatic int unsigned clamp_dim(input cfg_type v, input int unsigned top);
      if (v < 3) begin
         return 3;
      end
      if (v > top) begin
         return top;
      end
      return int'(v);
   endfunction

   task automatic smooth_pixel(input pixel_type pix_in, input logic flush);
      int unsigned        w, h, x, r, old_addr, new_addr, sum, i, j;
      pixel_type          pix, prev_right, value;
      smoothed_pixel_type res;
      logic               emit;
      w = clamp_dim(width_reg, MAX_LINE_WIDTH);
      h = clamp_dim(height_reg, MAX_ROWS);
      if (in_col >= w || in_row > h + 1 || out_col >= w || out_row >= h) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end
      x        = in_col;
      r        = in_row;
      pix      = flush ? '0 : pix_in;
      old_addr = (r % 2) * MAX_LINE_WIDTH + x;
      new_addr = ((r + 1) % 2) * MAX_LINE_WIDTH + x;
      prev_right = taps[1][2];
      for (i = 0; i < 3; i++) begin
         taps[i][0] = taps[i][1];
         taps[i][1] = taps[i][2];
      end
      taps[0][2] = line_mem[old_addr];
      taps[1][2] = line_mem[new_addr];
      taps[2][2] = pix;
      line_mem[old_addr] = pix;
      emit = (r >= 2) || (r == 1 && x >= 1);
      in_col = x + 1;
      if (in_col >= w) begin
         in_col = 0;
         in_row = r + 1;
      end
      if (emit) begin
         if (out_col == w - 1) begin
            value = prev_right;
         end else if (out_col == 0 || out_row == 0 || out_row == h - 1) begin
            value = taps[1][1];
         end else begin
            sum = 2 * taps[1][1];
            for (i = 0; i < 3; i++) begin
               for (j = 0; j < 3; j++) begin
                  sum += taps[i][j];
               end
            end
            value = pixel_type'(sum / 11);
         end
         res.pixel     = value;
         res.frame_end = (out_row == h - 1) && (out_col == w - 1);
         if (res.frame_end) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
         end else begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
         smoothed_due.push_back(res);
      end
   endtask

   task automatic push_req(input pixel_type pix, input logic flush);
      pixel_req_type item;
      item.pixel = pix;
      item.flush = flush;
      pixel_backlog.push_back(item);
   endtask

   // Requests first to last-1 of a w by h pixel frame; those past the frame flush.
   task automatic queue_frame_part(input int unsigned w, input int unsigned h,
                                   input int unsigned first, input int unsigned last);
      int unsigned k;
      for (k = first; k < last; k++) begin
         if (k >= w * h) begin
            push_req(pixel_type'($urandom_range(0, 255)), 1'b1);
         end else if ($urandom_range(0, 29) == 0) begin
            push_req(pixel_type'($urandom_range(0, 255)), 1'b1);
         end else if ($urandom_range(0, 7) == 0) begin
            push_req($urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
         end else begin
            push_req(pixel_type'($urandom_range(0, 255)), 1'b0);
         end
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pixel_backlog.size() != 0 || req_valid || smoothed_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_size(input cfg_type w, input cfg_type h);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= w;
      width_reg = w;
      @(posedge clock);
      csr_index        <= CSR_IMAGE_HEIGHT;
      csr_write_data   <= h;
      height_reg = h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic cfg_type pick_dim(input int unsigned top);
      if ($urandom_range(0, 9) == 0) begin
         return cfg_type'($urandom_range(0, 2));
      end
      return cfg_type'($urandom_range(3, top));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            smooth_pixel(req_pixel_value, req_is_flush);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               staged_req = pixel_backlog.pop_front();
               req_valid       <= 1'b1;
               req_pixel_value <= staged_req.pixel;
               req_is_flush    <= staged_req.flush;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                            : $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 15)
                                                            : $urandom_range(0, 3);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(50, 200);
            rsp_stall <= 1'b0;
         end else begin
            stall_left = $urandom_range(1, 8);
            rsp_stall <= 1'($urandom_range(0, 1));
         end
      end else begin
         stall_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (smoothed_due.size() == 0) begin
            flag_error($sformatf("pixel %0d frame_end %0d arrived with nothing expected",
                                 rsp_filtered_pixel, rsp_frame_end));
         end else begin
            due_pixel = smoothed_due.pop_front();
            if (rsp_filtered_pixel !== due_pixel.pixel) begin
               flag_error($sformatf("filtered_pixel %0d, expected %0d",
                                    rsp_filtered_pixel, due_pixel.pixel));
            end
            if (rsp_frame_end !== due_pixel.frame_end) begin
               flag_error($sformatf("frame_end %0d, expected %0d",
                                    rsp_frame_end, due_pixel.frame_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("weighted_3x3_smoothing_filter_test: done, errors");
         $finish;
      end
   end

   initial begin
      int unsigned sent_items;
      int unsigned w, h, frame_len, cut, extra;
      cfg_type     w_code, h_code;
      sent_items = 0;
      foreach (line_mem[a]) begin
         line_mem[a] = '0;
      end
      foreach (taps[a, b]) begin
         taps[a][b] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Part of a frame at the reset size; the size change below lands mid-frame.
      queue_frame_part(640, 480, 0, 660);
      sent_items += 660;

      program_size(3, 3);
      // Bright ring around a dark center, then the reverse with a flush in the frame.
      repeat (4) push_req(8'hFF, 1'b0);
      push_req(8'h00, 1'b0);
      repeat (4) push_req(8'hFF, 1'b0);
      repeat (4) push_req(8'hAA, 1'b1);
      push_req(8'hFF, 1'b1);
      repeat (3) push_req(8'h00, 1'b0);
      push_req(8'hFF, 1'b0);
      repeat (4) push_req(8'h00, 1'b0);
      repeat (4) push_req(8'h55, 1'b1);
      sent_items += 26;

      // The start of the widest and the tallest frames, written as out-of-range values.
      program_size(8191, 3);
      queue_frame_part(MAX_LINE_WIDTH, 3, 0, 30);
      sent_items += 30;
      program_size(0, 8191);
      queue_frame_part(3, MAX_ROWS, 0, 40);
      sent_items += 40;

      while (sent_items < TARGET_ITEMS) begin
         w_code = pick_dim(10);
         h_code = pick_dim(6);
         program_size(w_code, h_code);
         w = clamp_dim(w_code, MAX_LINE_WIDTH);
         h = clamp_dim(h_code, MAX_ROWS);
         frame_len = w * h + w + 1;
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 9))
               0: begin
                  cut = $urandom_range(1, frame_len - 1);
                  queue_frame_part(w, h, 0, cut);
                  sent_items += cut;
               end
               1: begin
                  queue_frame_part(w, h, 0, frame_len / 2);
                  wait_drained();
                  queue_frame_part(w, h, frame_len / 2, frame_len);
                  sent_items += frame_len;
               end
               2: begin
                  extra = $urandom_range(1, 6);
                  queue_frame_part(w, h, 0, frame_len);
                  queue_frame_part(w, h, 0, extra);
                  sent_items += frame_len + extra;
               end
               default: begin
                  queue_frame_part(w, h, 0, frame_len);
                  sent_items += frame_len;
               end
            endcase
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("weighted_3x3_smoothing_filter_test: done, clean");
      end else begin
         $display("weighted_3x3_smoothing_filter_test: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/wsf_pkg.sv
rtl/wsf_ram.sv
rtl/wsf_front.sv
rtl/wsf_queue.sv
rtl/wsf_back.sv
rtl/weighted_3x3_smoothing_filter.sv
tb/sv/weighted_3x3_smoothing_filter_test.sv
